### hw/rtl/urff_pkg.sv
// Shared types, character codes and helpers for the unsigned radix field formatter.
package urff_pkg;

  localparam int DIGIT_MAX = 32;
  localparam int BITS_PER_CYCLE = 8;
  localparam int DIV_CYCLES = 32 / BITS_PER_CYCLE;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ALPHA = 8'h57;  // 'a' - 10

  localparam logic [1:0] MODE_ZERO_FILL = 2'd1;
  localparam logic signed [7:0] NO_PREC = -8'sd1;

  typedef struct packed {
    logic [31:0]       value;
    logic [4:0]        radix;
    logic [6:0]        field_width;
    logic signed [7:0] min_digits;
    logic [6:0]        prefix_room;
    logic [1:0]        justify_mode;
  } fmt_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
  } fmt_char_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_SETUP,
    S_EMIT
  } fmt_state_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'd0, d};
    end else begin
      c = CH_ALPHA + {4'd0, d};
    end
    return c;
  endfunction

endpackage

### hw/rtl/unsigned_radix_field_formatter.sv
// Formats an unsigned 32-bit value as a padded ASCII field, one character per cycle.
// Each digit is one pass through a shared 8-bit-per-cycle restoring divider, then a setup
// state lays out the field, then one character per cycle leaves through the output register.
// busy is high while an item is divided, set up and emitted; start is taken only in idle.
// Synchronous active-high reset returns the sequencer to idle with no result pending.
module unsigned_radix_field_formatter #(
  parameter int MAX_FIELD = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  urff_pkg::fmt_item_t  item,
  output logic                 busy,
  output logic                 result_valid,
  output urff_pkg::fmt_char_t  result
);
  import urff_pkg::*;

  localparam int SPAN  = (MAX_FIELD > DIGIT_MAX) ? MAX_FIELD : DIGIT_MAX;
  localparam int CNT_W = $clog2(SPAN + 1);
  localparam int SW    = (CNT_W > 7) ? CNT_W + 1 : 8;
  localparam int ND_W  = $clog2(DIGIT_MAX + 1);
  localparam int DI_W  = $clog2(DIGIT_MAX);
  localparam int STP_W = $clog2(DIV_CYCLES);

  fmt_state_t state, state_next;

  // item set-up, latched on the input transfer
  logic [4:0]       rdx;
  logic [CNT_W-1:0] prec, tp;
  logic             zero_pad, left;

  // divider
  logic [31:0]      dv, qacc;
  logic [3:0]       rem;
  logic [STP_W-1:0] step;
  logic [31:0]      q_new;
  logic [3:0]       r_new;

  // digit store, least significant first
  logic [3:0]       dig [DIGIT_MAX];
  logic [ND_W-1:0]  nd;

  // emit phase
  logic [CNT_W-1:0] total, lead, pos;
  logic [CNT_W-1:0] nd_ext, body, e1, e2, e3, dend, didx_full;
  logic [7:0]       ch;

  // input decode
  logic [CNT_W-1:0] w_sat, prec_in, tot0, tp_in;
  logic [4:0]       rdx_in;
  logic             accept, div_done, emit_end;

  assign accept = start && (state == S_IDLE);

  always_comb begin
    if (int'(item.field_width) > MAX_FIELD) begin
      w_sat = CNT_W'(MAX_FIELD);
    end else begin
      w_sat = CNT_W'(item.field_width);
    end
    if (item.min_digits > 8'sd0) begin
      if (int'(item.min_digits) > MAX_FIELD) begin
        prec_in = CNT_W'(MAX_FIELD);
      end else begin
        prec_in = CNT_W'(item.min_digits);
      end
    end else begin
      prec_in = '0;
    end
    if (SW'(w_sat) > SW'(item.prefix_room)) begin
      tot0 = CNT_W'(SW'(w_sat) - SW'(item.prefix_room));
    end else begin
      tot0 = '0;
    end
    tp_in = (tot0 > prec_in) ? tot0 : prec_in;
    if (item.radix < 5'd2) begin
      rdx_in = 5'd2;
    end else if (item.radix > 5'd16) begin
      rdx_in = 5'd16;
    end else begin
      rdx_in = item.radix;
    end
  end

  // eight restoring steps per cycle; remainder stays below the radix
  always_comb begin
    logic [4:0] t;
    logic [3:0] r;
    logic [31:0] q;
    r = rem;
    q = qacc;
    for (int i = 0; i < BITS_PER_CYCLE; i++) begin
      t = {r, dv[31 - i]};
      if (t >= rdx) begin
        t = t - rdx;
        q = {q[30:0], 1'b1};
      end else begin
        q = {q[30:0], 1'b0};
      end
      r = t[3:0];
    end
    q_new = q;
    r_new = r;
  end

  assign div_done = (step == STP_W'(DIV_CYCLES - 1)) && (q_new == '0);

  // field layout: right = [pad][zeros][digits], left = [zeros][digits][spaces]
  always_comb begin
    nd_ext = CNT_W'(nd);
    body   = lead + nd_ext;
    if (left) begin
      e1   = '0;
      e2   = lead;
      e3   = body;
      dend = body - 1'b1;
    end else begin
      e1   = total - body;
      e2   = total - nd_ext;
      e3   = total;
      dend = total - 1'b1;
    end
    didx_full = dend - pos;
    if (pos < e1) begin
      ch = zero_pad ? CH_ZERO : CH_SPACE;
    end else if (pos < e2) begin
      ch = CH_ZERO;
    end else if (pos < e3) begin
      ch = digit_char(dig[didx_full[DI_W-1:0]]);
    end else begin
      ch = CH_SPACE;
    end
  end

  assign emit_end = (pos == total - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (emit_end) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= (state == S_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rdx      <= rdx_in;
      prec     <= prec_in;
      tp       <= tp_in;
      zero_pad <= (item.justify_mode == MODE_ZERO_FILL) && (item.min_digits == NO_PREC);
      left     <= item.justify_mode[1];
      dv       <= item.value;
      rem      <= '0;
      step     <= '0;
      nd       <= '0;
    end
    if (state == S_DIV) begin
      if (step == STP_W'(DIV_CYCLES - 1)) begin
        dig[nd[DI_W-1:0]] <= r_new;
        nd   <= nd + 1'b1;
        dv   <= q_new;
        rem  <= '0;
        step <= '0;
      end else begin
        dv   <= {dv[31-BITS_PER_CYCLE:0], {BITS_PER_CYCLE{1'b0}}};
        rem  <= r_new;
        step <= step + 1'b1;
      end
      qacc <= q_new;
    end
    if (state == S_SETUP) begin
      total <= (tp > nd_ext) ? tp : nd_ext;
      lead  <= (prec > nd_ext) ? prec - nd_ext : '0;
      pos   <= '0;
    end
    if (state == S_EMIT) begin
      pos             <= pos + 1'b1;
      result.out_char <= ch;
      result.last     <= emit_end;
    end
  end

`ifndef ASSERT_OFF
  a_res_from_emit: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state == S_EMIT))
    else $error("result without emit cycle");

  a_start_divides: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (state == S_DIV))
    else $error("accepted transfer did not start division");

  // digit count is cleared on a transfer and grows by one per digit
  a_digit_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> (nd <= ND_W'(DIGIT_MAX)))
    else $error("digit count overflow");

  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last) |=> !result_valid)
    else $error("character after end of field");

  a_idle_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !busy) |-> result.last)
    else $error("field ended without last flag");
`endif

endmodule

### bench/unsigned_radix_field_formatter_test.sv
// Testbench for the unsigned radix field formatter: directed and random fields, checked per character.
module unsigned_radix_field_formatter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import urff_pkg::*;

  localparam int FIELD_LIMIT = 64;
  localparam logic [1:0] MODE_RIGHT = 2'd0;
  localparam logic [1:0] MODE_LEFT = 2'd2;
  localparam logic [1:0] MODE_LEFT_ALT = 2'd3;
  localparam int DRAIN_CYCLES = 4 * DIGIT_MAX + FIELD_LIMIT + 16;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PRINT_LIMIT = 100;

  logic clk;
  logic rst;
  logic start;
  fmt_item_t item;
  logic busy;
  logic result_valid;
  fmt_char_t result;

  fmt_char_t expected_chars[$];
  fmt_char_t want_char;
  int mismatch_count = 0;
  int cycle_count = 0;

  unsigned_radix_field_formatter DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .item(item),
    .busy(busy),
    .result_valid(result_valid),
    .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_LIMIT) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  // Expected characters of one field, appended in output order.
  task automatic predict_field(input fmt_item_t it);
    logic [7:0] digs[DIGIT_MAX];
    logic [7:0] chars[$];
    logic [7:0] padch;
    fmt_char_t c;
    int unsigned v;
    int unsigned r;
    int unsigned d;
    int w;
    int pr;
    int room;
    int nd;
    int prec;
    int total;
    int lead;
    int pad;
    bit left;
    v = it.value;
    r = it.radix;
    w = it.field_width;
    pr = it.min_digits;
    room = it.prefix_room;
    nd = 0;
    if (r < 2) r = 2;
    if (r > 16) r = 16;
    if (w > FIELD_LIMIT) w = FIELD_LIMIT;
    if (pr > FIELD_LIMIT) pr = FIELD_LIMIT;
    if (v == 0) begin
      digs[0] = CH_ZERO;
      nd = 1;
    end
    while (v > 0 && nd < DIGIT_MAX) begin
      d = v % r;
      digs[nd] = (d < 10) ? CH_ZERO + 8'(d) : CH_ALPHA + 8'(d);
      nd++;
      v = v / r;
    end
    prec = (pr > 0) ? pr : 0;
    total = w - room;
    if (total < prec) total = prec;
    if (total < nd) total = nd;
    lead = (prec > nd) ? prec - nd : 0;
    pad = total - lead - nd;
    left = (it.justify_mode >= MODE_LEFT);
    // zero padding only when precision is exactly absent
    padch = (it.justify_mode == MODE_ZERO_FILL && it.min_digits == NO_PREC) ? CH_ZERO : CH_SPACE;
    if (!left) begin
      for (int i = 0; i < pad; i++) chars.push_back(padch);
    end
    for (int i = 0; i < lead; i++) chars.push_back(CH_ZERO);
    for (int i = nd - 1; i >= 0; i--) chars.push_back(digs[i]);
    if (left) begin
      for (int i = 0; i < pad; i++) chars.push_back(CH_SPACE);
    end
    foreach (chars[i]) begin
      c.out_char = chars[i];
      c.last = (i == chars.size() - 1);
      expected_chars.push_back(c);
    end
  endtask

  function automatic fmt_item_t make_item(input logic [31:0] value, input int radix,
                                          input int width, input int prec,
                                          input int room, input logic [1:0] mode);
    fmt_item_t it;
    it.value = value;
    it.radix = 5'(radix);
    it.field_width = 7'(width);
    it.min_digits = 8'(prec);
    it.prefix_room = 7'(room);
    it.justify_mode = mode;
    return it;
  endfunction

  function automatic int idle_gap();
    return ($urandom_range(0, 1) == 0) ? 0 : int'($urandom_range(1, 3));
  endfunction

  // Leaves start high after the transfer so a following item can go straight in.
  task automatic send_item(input fmt_item_t it, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_field(it);
  endtask

  // Mostly legal fields, small sizes, with content random throughout.
  function automatic fmt_item_t legal_item();
    fmt_item_t it;
    int sel;
    it.value = $urandom() >> $urandom_range(0, 31);
    it.radix = 5'($urandom_range(2, 16));
    sel = $urandom_range(0, 9);
    it.field_width = 7'((sel == 0) ? $urandom_range(0, 64) : $urandom_range(0, 16));
    sel = $urandom_range(0, 9);
    if (sel < 4) it.min_digits = NO_PREC;
    else if (sel == 4) it.min_digits = 8'($urandom_range(0, 64));
    else it.min_digits = 8'($urandom_range(0, 12));
    it.prefix_room = 7'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : 0);
    it.justify_mode = 2'($urandom_range(0, 2));
    return it;
  endfunction

  function automatic fmt_item_t noise_item();
    fmt_item_t it;
    it.value = $urandom();
    it.radix = 5'($urandom());
    it.field_width = 7'($urandom());
    it.min_digits = 8'($urandom());
    it.prefix_room = 7'($urandom());
    it.justify_mode = 2'($urandom());
    return it;
  endfunction

  task automatic test_directed();
    fmt_item_t items[$];
    items.push_back(make_item(32'd0, 10, 0, 0, 0, MODE_RIGHT));
    items.push_back(make_item(32'd0, 10, 5, -1, 0, MODE_ZERO_FILL));
    items.push_back(make_item(32'hffff_ffff, 2, 64, -1, 0, MODE_RIGHT));
    items.push_back(make_item(32'hffff_ffff, 16, 0, -1, 0, MODE_RIGHT));
    items.push_back(make_item(32'hffff_ffff, 3, 0, -1, 0, MODE_ZERO_FILL));
    items.push_back(make_item(32'd12345, 10, 10, -1, 0, MODE_LEFT));
    items.push_back(make_item(32'd255, 16, 8, 4, 0, MODE_ZERO_FILL));
    items.push_back(make_item(32'd255, 16, 8, -1, 2, MODE_ZERO_FILL));
    items.push_back(make_item(32'd42, 0, 8, -1, 0, MODE_RIGHT));
    items.push_back(make_item(32'd42, 1, 0, -1, 0, MODE_RIGHT));
    items.push_back(make_item(32'd42, 17, 4, -1, 0, MODE_ZERO_FILL));
    items.push_back(make_item(32'hdead_beef, 31, 0, -1, 0, MODE_RIGHT));
    items.push_back(make_item(32'd7, 10, 127, -1, 0, MODE_ZERO_FILL));
    items.push_back(make_item(32'd7, 10, 0, 127, 0, MODE_RIGHT));
    items.push_back(make_item(32'd7, 10, 64, 64, 0, MODE_LEFT));
    items.push_back(make_item(32'd7, 10, 6, -2, 0, MODE_ZERO_FILL));
    items.push_back(make_item(32'd7, 10, 6, -128, 0, MODE_ZERO_FILL));
    items.push_back(make_item(32'd123, 10, 3, 5, 10, MODE_RIGHT));
    items.push_back(make_item(32'd123, 10, 10, -1, 127, MODE_ZERO_FILL));
    items.push_back(make_item(32'd123, 10, 8, -1, 0, MODE_LEFT_ALT));
    items.push_back(make_item(32'd0, 16, 4, 0, 0, MODE_LEFT));
    items.push_back(make_item(32'h8000_0000, 16, 12, 10, 1, MODE_LEFT));
    items.push_back(make_item(32'd1, 2, 1, 1, 0, MODE_ZERO_FILL));
    items.push_back(make_item(32'd35, 36, 0, -1, 0, MODE_RIGHT));
    foreach (items[i]) send_item(items[i], idle_gap());
  endtask

  task automatic test_random_fields();
    for (int n = 0; n < 75; n++) send_item(legal_item(), idle_gap());
  endtask

  task automatic test_full_range_noise();
    for (int n = 0; n < 15; n++) send_item(noise_item(), idle_gap());
  endtask

  task automatic test_back_to_back();
    for (int n = 0; n < 16; n++) begin
      send_item(($urandom_range(0, 3) == 0) ? noise_item() : legal_item(), 0);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("character 0x%02h with none pending", result.out_char));
      end else begin
        want_char = expected_chars.pop_front();
        if (result.out_char !== want_char.out_char) begin
          report_mismatch($sformatf("out_char 0x%02h, wanted 0x%02h",
                                    result.out_char, want_char.out_char));
        end
        if (result.last !== want_char.last) begin
          report_mismatch($sformatf("last %b, wanted %b (char 0x%02h)",
                                    result.last, want_char.last, want_char.out_char));
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_fields();
    test_full_range_noise();
    test_back_to_back();
    start <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
